>>> hdl/lsp_pkg.sv
// Shared types, sizes and codes for the LIFO stack with peek.
// No dependencies; imported by lsp_ctrl and lifo_stack_with_peek.
`timescale 1ns / 1ps

package lsp_pkg;

   localparam int DEPTH      = 16;
   localparam int WORD_WIDTH = 32;
   localparam int ADDR_W     = $clog2(DEPTH);

   // Fixed field widths
   localparam int DATA_W = 32;
   localparam int CNT_W  = 5;
   localparam int KIND_W = 2;
   localparam int STAT_W = 2;

   localparam logic [CNT_W-1:0] DEPTH_CNT   = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(16);

   // Request kinds
   localparam logic [KIND_W-1:0] KIND_PUSH   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_POP    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_PEEK   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_BOTTOM = 2'd3;

   // Result status
   localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
   localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd1;
   localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;
   localparam logic [STAT_W-1:0] ST_BADPOS   = 2'd3;

   // Decoded request, from control to the datapath
   typedef struct packed {
      logic              we;      // push that fits: write entry
      logic              rd_ok;   // successful read: take memory data
      logic [ADDR_W-1:0] addr;    // entry to write or read
      logic [STAT_W-1:0] status;
      logic [CNT_W-1:0]  count;   // count after this request
   } op_type;

endpackage

>>> hdl/lsp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lsp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/lsp_ctrl.sv
// Stack control: fill count, limit register and request decode.
// Depends on lsp_pkg.
`timescale 1ns / 1ps

module lsp_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic [lsp_pkg::KIND_W-1:0]   kind,
   input  logic [lsp_pkg::CNT_W-1:0]    position,
   input  logic                         csr_we,
   input  logic [lsp_pkg::CNT_W-1:0]    csr_wdata,
   output lsp_pkg::op_type              op
);
   import lsp_pkg::*;

   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] limit_ff, limit_in;
   logic [CNT_W-1:0] lim_use;
   logic [CNT_W-1:0] peek_idx;

   assign lim_use  = (limit_ff > DEPTH_CNT) ? DEPTH_CNT : limit_ff;
   assign peek_idx = fill_ff - position;

   always_comb begin
      op        = '0;
      op.status = ST_OK;
      op.count  = fill_ff;
      case (kind)
         KIND_PUSH: begin
            if (fill_ff >= lim_use || fill_ff >= DEPTH_CNT) begin
               op.status = ST_OVERFLOW;
            end else begin
               op.we    = 1'b1;
               op.addr  = fill_ff[ADDR_W-1:0];
               op.count = fill_ff + 1'b1;
            end
         end
         KIND_POP: begin
            if (fill_ff == '0 || fill_ff > DEPTH_CNT) begin
               op.status = ST_EMPTY;
            end else begin
               op.rd_ok = 1'b1;
               op.addr  = ADDR_W'(fill_ff - 1'b1);
               op.count = fill_ff - 1'b1;
            end
         end
         KIND_PEEK: begin
            if (position == '0 || position > fill_ff || peek_idx >= DEPTH_CNT) begin
               op.status = ST_BADPOS;
            end else begin
               op.rd_ok = 1'b1;
               op.addr  = peek_idx[ADDR_W-1:0];
            end
         end
         KIND_BOTTOM: begin
            if (fill_ff == '0) begin
               op.status = ST_EMPTY;
            end else begin
               op.rd_ok = 1'b1;
            end
         end
         default: begin
            op.status = ST_OK;
         end
      endcase
   end

   assign fill_in  = accept ? op.count : fill_ff;
   assign limit_in = csr_we ? csr_wdata : limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         limit_ff <= LIMIT_RESET;
      end else begin
         fill_ff  <= fill_in;
         limit_ff <= limit_in;
      end
   end

endmodule

>>> hdl/lifo_stack_with_peek.sv
// Top level of the LIFO stack with peek and bottom read.
// Depends on lsp_pkg, lsp_ram and lsp_ctrl.
`timescale 1ns / 1ps

//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | kind, push_value, position
//  rsp     | out       | rsp_valid/rsp_ready  | data, status, count
//  csr     | in        | csr_we (no wait)     | csr_wdata = stack limit
//
// One request per cycle while req_ready is high; a result is offered on rsp
// once it has passed the pending stage (for the registered read of the
// entry memory) and then the output register.
// Reset (synchronous) empties the stack and sets the limit to 16; entry
// contents are left as they are, only entries below the count are read.
// A stalled result holds in the output register; one more request is
// taken into the pending stage, then req_ready drops until rsp moves.

module lifo_stack_with_peek (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [lsp_pkg::KIND_W-1:0]    req_kind,
   input  logic signed [lsp_pkg::DATA_W-1:0] req_push_value,
   input  logic [lsp_pkg::CNT_W-1:0]     req_position,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [lsp_pkg::DATA_W-1:0] rsp_data,
   output logic [lsp_pkg::STAT_W-1:0]    rsp_status,
   output logic [lsp_pkg::CNT_W-1:0]     rsp_count,
   // configuration
   input  logic                          csr_we,
   input  logic [lsp_pkg::CNT_W-1:0]     csr_wdata
);
   import lsp_pkg::*;

   op_type            op;
   logic              accept;
   logic              advance;

   // memory read address: new on accept, otherwise held so that the
   // read data stays valid while a result waits in the pending stage
   logic [ADDR_W-1:0] raddr_ff, raddr_in;
   logic [WORD_WIDTH-1:0] ram_q;

   // pending stage: request decided, memory data arriving
   logic              pend_valid_ff, pend_valid_in;
   logic              pend_rd_ff;
   logic [STAT_W-1:0] pend_status_ff;
   logic [CNT_W-1:0]  pend_count_ff;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff;
   logic [STAT_W-1:0] rsp_status_ff;
   logic [CNT_W-1:0]  rsp_count_ff;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !pend_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   lsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .kind      (req_kind),
      .position  (req_position),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .op        (op)
   );

   assign raddr_in = accept ? op.addr : raddr_ff;

   lsp_ram #(
      .WIDTH (WORD_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (accept && op.we),
      .wr_addr (op.addr),
      .wr_data (WORD_WIDTH'($unsigned(req_push_value))),
      .rd_addr (raddr_in),
      .rd_data (ram_q)
   );

   // pending slot refills whenever it is empty or moving on
   assign pend_valid_in = (!pend_valid_ff || advance) ? accept : pend_valid_ff;
   assign rsp_valid_in  = advance ? pend_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      raddr_ff <= raddr_in;
      if (accept) begin
         pend_rd_ff     <= op.rd_ok;
         pend_status_ff <= op.status;
         pend_count_ff  <= op.count;
      end
      if (advance && pend_valid_ff) begin
         rsp_data_ff   <= pend_rd_ff ? DATA_W'(ram_q) : '0;
         rsp_status_ff <= pend_status_ff;
         rsp_count_ff  <= pend_count_ff;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_count  = rsp_count_ff;

endmodule

>>> tb/tb_lifo_stack_with_peek.sv
// Self-checking bench for lifo_stack_with_peek: directed and random requests,
// a shadow stack predicting each result, random idling on both channels.
// Depends on lsp_pkg and the lifo_stack_with_peek RTL.
`timescale 1ns / 1ps

module tb_lifo_stack_with_peek;
   import lsp_pkg::*;

   localparam int QUIET_LIMIT  = 2000;   // cycles with no handshake before giving up
   localparam int PHASE_ITEMS  = 158;
   localparam int LONG_HOLD    = 80;     // receiver hold-off, long enough to fill the pipe

   localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;

   // one result as it should appear on the rsp channel
   typedef struct {
      logic signed [DATA_W-1:0] data;
      logic [STAT_W-1:0]        status;
      logic [CNT_W-1:0]         count;
   } stack_result_type;

   // Shadow copy of the stack: predicts the result of each accepted request
   // and checks the results against them in order.
   class stack_shadow;
      logic signed [DATA_W-1:0] words [DEPTH];
      int unsigned              fill;
      logic [CNT_W-1:0]         limit;
      stack_result_type         awaited [$];
      int unsigned              checked;
      int unsigned              mismatches;
      int unsigned              status_seen [4];

      function new();
         fill       = 0;
         limit      = LIMIT_RESET;
         checked    = 0;
         mismatches = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      function void report(string what);
         mismatches++;
         if (mismatches <= 10) $display("MISMATCH: %s", what);
      endfunction

      function void take_request(logic [KIND_W-1:0] kind, logic signed [DATA_W-1:0] value,
                                 logic [CNT_W-1:0] pos);
         stack_result_type r;
         int unsigned      lim;
         lim      = (limit > DEPTH) ? DEPTH : limit;   // limit above depth acts as depth
         r.data   = '0;
         r.status = ST_OK;
         case (kind)
            KIND_PUSH: begin
               if (fill >= lim) begin
                  r.status = ST_OVERFLOW;
               end else begin
                  words[fill] = value;
                  fill++;
               end
            end
            KIND_POP: begin
               if (fill == 0) begin
                  r.status = ST_EMPTY;
               end else begin
                  fill--;
                  r.data = words[fill];
               end
            end
            KIND_PEEK: begin
               // position zero or past the count is a bad position, empty or not
               if (pos == 0 || pos > fill) r.status = ST_BADPOS;
               else r.data = words[fill - pos];
            end
            default: begin
               if (fill == 0) r.status = ST_EMPTY;
               else r.data = words[0];
            end
         endcase
         r.count = CNT_W'(fill);
         status_seen[r.status]++;
         awaited.push_back(r);
      endfunction

      function void check_result(logic signed [DATA_W-1:0] data, logic [STAT_W-1:0] status,
                                 logic [CNT_W-1:0] count);
         stack_result_type want;
         checked++;
         if (awaited.size() == 0) begin
            report($sformatf({"result %0d arrived with no request outstanding: ",
                              "data %0d status %0d count %0d"},
                             checked, data, status, count));
         end else begin
            want = awaited.pop_front();
            if (data !== want.data || status !== want.status || count !== want.count)
               report($sformatf({"result %0d: expected data %0d status %0d count %0d, ",
                                 "got data %0d status %0d count %0d"},
                                checked, want.data, want.status, want.count,
                                data, status, count));
         end
      endfunction
   endclass

   // ---------------------------------------------------------------------
   // Block signals; every input is driven to a known value from time zero
   // ---------------------------------------------------------------------
   logic                     clock          = 1'b0;
   logic                     reset          = 1'b1;
   logic                     req_valid      = 1'b0;
   logic                     req_ready;
   logic [KIND_W-1:0]        req_kind       = KIND_PUSH;
   logic signed [DATA_W-1:0] req_push_value = '0;
   logic [CNT_W-1:0]         req_position   = '0;
   logic                     rsp_valid;
   logic                     rsp_ready      = 1'b0;
   logic signed [DATA_W-1:0] rsp_data;
   logic [STAT_W-1:0]        rsp_status;
   logic [CNT_W-1:0]         rsp_count;
   logic                     csr_we         = 1'b0;
   logic [CNT_W-1:0]         csr_wdata      = '0;

   stack_shadow shadow = new();

   int req_streak      = 0;   // requests left in a run with no idling
   int rsp_streak      = 0;   // same for the receiver
   int rsp_hold_cycles = 0;   // set by the stimulus to ask for a long receiver hold-off
   int sent            = 0;
   int limits_used     = 0;
   int long_holds      = 0;
   int quiet_cycles    = 0;

   lifo_stack_with_peek dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_push_value (req_push_value),
      .req_position   (req_position),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .rsp_status     (rsp_status),
      .rsp_count      (rsp_count),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Watchdog: a stuck handshake on either side ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Watchdog: no handshake for %0d cycles, %0d results outstanding",
                  quiet_cycles, shadow.awaited.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   // Random idle cycles before the next request or result, with occasional
   // runs of back-to-back transfers so that full-rate behaviour is seen too.
   function automatic int draw_gap(inout int streak);
      if (streak > 0) begin
         streak--;
         return 0;
      end
      if ($urandom_range(0, 30) == 0) streak = $urandom_range(10, 40);
      return $urandom_range(0, 17);
   endfunction

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------
   // Valid is only dropped when a gap follows, so it is never lowered and
   // raised in the same step. Payload is held until the handshake.
   task automatic send_request(logic [KIND_W-1:0] kind, logic signed [DATA_W-1:0] value,
                               logic [CNT_W-1:0] pos);
      int gap;
      gap = draw_gap(req_streak);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_push_value <= value;
      req_position   <= pos;
      do @(posedge clock); while (req_ready !== 1'b1);
      shadow.take_request(kind, value, pos);
      sent++;
   endtask

   // Stop offering requests and wait until every result has been taken.
   // Each request gives exactly one result, so the block is then idle.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (shadow.awaited.size() != 0);
   endtask

   // Limit register: single-cycle write, only ever issued with the block idle.
   task automatic write_limit(logic [CNT_W-1:0] lim);
      csr_we    <= 1'b1;
      csr_wdata <= lim;
      @(posedge clock);
      csr_we    <= 1'b0;
      shadow.limit = lim;
      limits_used++;
   endtask

   // Random request, biased to push while filling and pop while draining so
   // that full and empty are reached often. Peek positions mostly fall
   // within or just past the count, sometimes anywhere.
   task automatic send_random(bit filling);
      logic [KIND_W-1:0]        kind;
      logic signed [DATA_W-1:0] value;
      logic [CNT_W-1:0]         pos;
      int                       pick;
      int                       top;
      pick = $urandom_range(0, 99);
      if (filling) begin
         if (pick < 55)      kind = KIND_PUSH;
         else if (pick < 70) kind = KIND_POP;
         else if (pick < 90) kind = KIND_PEEK;
         else                kind = KIND_BOTTOM;
      end else begin
         if (pick < 15)      kind = KIND_PUSH;
         else if (pick < 65) kind = KIND_POP;
         else if (pick < 90) kind = KIND_PEEK;
         else                kind = KIND_BOTTOM;
      end
      case ($urandom_range(0, 7))
         0:       value = WORD_MIN;
         1:       value = WORD_MAX;
         2:       value = ($urandom_range(0, 1) == 0) ? 32'sd0 : -32'sd1;
         default: value = $urandom;
      endcase
      pick = $urandom_range(0, 7);
      top  = (shadow.fill >= 31) ? 31 : shadow.fill + 1;
      if (pick == 0)      pos = '0;
      else if (pick == 1) pos = CNT_W'($urandom_range(0, 31));
      else                pos = CNT_W'($urandom_range(1, top));
      send_request(kind, value, pos);
   endtask

   // One random phase at a given limit. It opens with a long receiver
   // hold-off while requests keep coming back to back, so the block fills
   // and stalls its input; halfway through the sender waits for a full drain.
   task automatic run_phase(logic [CNT_W-1:0] lim, int items);
      bit          filling;
      int unsigned eff;
      filling = 1'b1;
      eff     = (lim > DEPTH) ? DEPTH : lim;
      wait_drained();
      write_limit(lim);
      rsp_hold_cycles = LONG_HOLD;
      req_streak      = 30;
      for (int i = 0; i < items; i++) begin
         if (i == items / 2) wait_drained();
         if (shadow.fill == 0) filling = 1'b1;
         else if (shadow.fill >= eff) filling = 1'b0;
         else if ($urandom_range(0, 49) == 0) filling = !filling;
         send_random(filling);
      end
   endtask

   // ---------------------------------------------------------------------
   // Result side: random stalls, plus the long hold-off when asked for
   // ---------------------------------------------------------------------
   initial begin : rsp_side
      int gap;
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            gap             = rsp_hold_cycles;
            rsp_hold_cycles = 0;
            long_holds++;
         end else begin
            gap = draw_gap(rsp_streak);
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         shadow.check_result(rsp_data, rsp_status, rsp_count);
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin : stimulus
      logic [CNT_W-1:0] phase_limits [10];
      phase_limits = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd5, 5'd17, 5'd2, 5'd9, 5'd16, 5'd0};
      phase_limits[9] = CNT_W'($urandom_range(0, 31));

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty stack at the reset limit: pop, bottom and peeks all refused
      send_request(KIND_POP,    32'sd0, 5'd0);
      send_request(KIND_BOTTOM, 32'sd0, 5'd0);
      send_request(KIND_PEEK,   32'sd0, 5'd0);
      send_request(KIND_PEEK,   32'sd0, 5'd1);
      // extreme and alternating words
      send_request(KIND_PUSH, WORD_MIN,          5'd0);
      send_request(KIND_PUSH, WORD_MAX,          5'd31);
      send_request(KIND_PUSH, 32'sd0,            5'd0);
      send_request(KIND_PUSH, -32'sd1,           5'd0);
      send_request(KIND_PUSH, 32'sh5A5A_A5A5,    5'd0);
      send_request(KIND_PUSH, 32'shA5A5_5A5A,    5'd0);
      // peeks: top, oldest, one past the count, zero, all position bits set
      send_request(KIND_PEEK,   32'sd0, 5'd1);
      send_request(KIND_PEEK,   32'sd0, 5'd6);
      send_request(KIND_PEEK,   32'sd0, 5'd7);
      send_request(KIND_PEEK,   32'sd0, 5'd0);
      send_request(KIND_PEEK,   32'sd0, 5'd31);
      send_request(KIND_BOTTOM, 32'sd0, 5'd0);
      send_request(KIND_POP,    32'sd0, 5'd0);

      // limit dropped below the count: push refused, held entries still readable
      wait_drained();
      write_limit(5'd2);
      send_request(KIND_PUSH, 32'sd1234, 5'd0);
      send_request(KIND_POP,  32'sd0,    5'd0);
      send_request(KIND_PEEK, 32'sd0,    5'd4);

      // limit of zero: every push overflows; drain to empty and one pop beyond
      wait_drained();
      write_limit(5'd0);
      send_request(KIND_PUSH, -32'sd7, 5'd0);
      repeat (5) send_request(KIND_POP, 32'sd0, 5'd0);

      foreach (phase_limits[p]) run_phase(phase_limits[p], PHASE_ITEMS);

      wait_drained();
      repeat (4) @(posedge clock);
      if (shadow.awaited.size() != 0)
         shadow.report($sformatf("%0d results never arrived", shadow.awaited.size()));

      $display("Covered %0d requests over %0d limit settings, %0d long receiver hold-offs",
               sent, limits_used, long_holds);
      $display({"Results checked %0d: ok %0d, overflow %0d, empty %0d, ",
                "bad position %0d, %0d mismatches"},
               shadow.checked, shadow.status_seen[ST_OK], shadow.status_seen[ST_OVERFLOW],
               shadow.status_seen[ST_EMPTY], shadow.status_seen[ST_BADPOS], shadow.mismatches);
      if (shadow.mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
